/* rtl/core/nc_pkg.sv */
// nc_pkg: shared types, codes and constants of the noise channel
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package nc_pkg;

    // field widths
    localparam int unsigned OP_W      = 2;
    localparam int unsigned LEN_IN_W  = 6;
    localparam int unsigned LEVEL_W   = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 8;

    // state widths
    localparam int unsigned STEP_W    = 3;
    localparam int unsigned PERIOD_W  = 24;
    localparam int unsigned LFSR_W    = 15;
    localparam int unsigned LEN_CNT_W = 7;
    localparam int unsigned ENV_W     = 3;
    localparam int unsigned VOL_W     = 4;

    // constants
    localparam logic [LFSR_W-1:0]    LFSR_SEED   = 15'h7FFF;
    localparam logic [LEN_CNT_W-1:0] LEN_FULL    = 7'd64;
    localparam logic [PERIOD_W-1:0]  HALF_BASE   = 24'd8;
    localparam logic [VOL_W-1:0]     VOL_MAX     = 4'hF;
    localparam logic [STEP_W-1:0]    ENV_STEP    = 3'd7;
    localparam int unsigned          NARROW_TAP  = 6;
    localparam logic [4:0]           RATIO_SHIFT = 5'd4;

    // item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TIMER   = 2'd0,
        OP_FRAME   = 2'd1,
        OP_TRIGGER = 2'd2,
        OP_LENGTH  = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_RATIO      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SHIFT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_MODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_ENABLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_PERIOD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_INCREASE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_VOLUME      = 3'd6;

    // configuration register contents
    typedef struct packed {
        logic [2:0]       divide_ratio;
        logic [3:0]       clock_shift;
        logic             narrow_mode;
        logic             length_enable;
        logic [ENV_W-1:0] envelope_period;
        logic             envelope_increase;
        logic [VOL_W-1:0] start_volume;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               channel_on;
        logic               noise_bit;
    } res_t;

endpackage

/* rtl/core/nc_if.sv */
// nc_if: valid/ready channel interfaces for events, results and config writes
// depends on nc_pkg for field widths
`timescale 1ns / 1ps

// event item channel
interface nc_evt_if;
    logic                         valid;
    logic                         ready;
    logic [nc_pkg::OP_W-1:0]      operation;
    logic [nc_pkg::LEN_IN_W-1:0]  length_value;

    modport source (output valid, output operation, output length_value, input ready);
    modport sink   (input valid, input operation, input length_value, output ready);
endinterface

// result item channel
interface nc_res_if;
    logic                         valid;
    logic                         ready;
    logic [nc_pkg::LEVEL_W-1:0]   level;
    logic                         channel_on;
    logic                         noise_bit;

    modport source (output valid, output level, output channel_on, output noise_bit,
                    input ready);
    modport sink   (input valid, input level, input channel_on, input noise_bit,
                    output ready);
endinterface

// configuration write channel
interface nc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [nc_pkg::CFG_IDX_W-1:0] index;
    logic [nc_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/nc_cfg.sv */
// nc_cfg: configuration register file of the noise channel
// depends on nc_pkg; fed from the config write channel of the top level
`timescale 1ns / 1ps

module nc_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [nc_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [nc_pkg::CFG_DAT_W-1:0] wr_data,
    output nc_pkg::cfg_t                 cfg
);
    import nc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode a write into the addressed field, unknown indexes ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_DIVIDE_RATIO:      cfg_next.divide_ratio      = wr_data[2:0];
                REG_CLOCK_SHIFT:       cfg_next.clock_shift       = wr_data[3:0];
                REG_NARROW_MODE:       cfg_next.narrow_mode       = wr_data[0];
                REG_LENGTH_ENABLE:     cfg_next.length_enable     = wr_data[0];
                REG_ENVELOPE_PERIOD:   cfg_next.envelope_period   = wr_data[ENV_W-1:0];
                REG_ENVELOPE_INCREASE: cfg_next.envelope_increase = wr_data[0];
                REG_START_VOLUME:      cfg_next.start_volume      = wr_data[VOL_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/nc_eng.sv */
// nc_eng: channel state (period counter, lfsr, length, envelope) and its update
// depends on nc_pkg; driven by the registered event item from the top level
`timescale 1ns / 1ps

module nc_eng (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  nc_pkg::op_t                 operation,
    input  logic [nc_pkg::LEN_IN_W-1:0] length_value,
    input  nc_pkg::cfg_t                cfg,
    output nc_pkg::res_t                res
);
    import nc_pkg::*;

    logic [STEP_W-1:0]    step_reg,   step_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [LFSR_W-1:0]    lfsr_reg,   lfsr_next;
    logic [LEN_CNT_W-1:0] len_reg,    len_next;
    logic [ENV_W-1:0]     env_reg,    env_next;
    logic [VOL_W-1:0]     vol_reg,    vol_next;
    logic                 on_reg,     on_next;

    logic [PERIOD_W-1:0]  reload;
    logic                 fb;
    logic [ENV_W-1:0]     env_dec;

    // period reload value
    always_comb
    begin
        if (cfg.divide_ratio != 3'd0)
        begin
            reload = {{(PERIOD_W-3){1'b0}}, cfg.divide_ratio}
                     << ({1'b0, cfg.clock_shift} + RATIO_SHIFT);
        end
        else
        begin
            reload = HALF_BASE << cfg.clock_shift;
        end
    end

    assign fb      = lfsr_reg[0] ^ lfsr_reg[1];
    assign env_dec = env_reg - 3'd1;

    // next state for one event
    always_comb
    begin
        step_next   = step_reg;
        period_next = period_reg;
        lfsr_next   = lfsr_reg;
        len_next    = len_reg;
        env_next    = env_reg;
        vol_next    = vol_reg;
        on_next     = on_reg;
        case (operation)
            OP_TIMER:
            begin
                if (period_reg <= 24'd1)
                begin
                    period_next = reload;
                    lfsr_next   = {fb, lfsr_reg[LFSR_W-1:1]};
                    if (cfg.narrow_mode)
                    begin
                        lfsr_next[NARROW_TAP] = fb;
                    end
                end
                else
                begin
                    period_next = period_reg - 24'd1;
                end
            end
            OP_FRAME:
            begin
                step_next = step_reg + 3'd1;
                // length clock on even steps
                if (!step_next[0] && cfg.length_enable && (len_reg != '0))
                begin
                    len_next = len_reg - 7'd1;
                    if (len_next == '0)
                    begin
                        on_next = 1'b0;
                    end
                end
                // envelope clock on the last step
                if ((step_next == ENV_STEP) && (cfg.envelope_period != '0))
                begin
                    env_next = env_dec;
                    if (env_dec == '0)
                    begin
                        env_next = cfg.envelope_period;
                        if (cfg.envelope_increase)
                        begin
                            if (vol_reg != VOL_MAX)
                            begin
                                vol_next = vol_reg + 4'd1;
                            end
                        end
                        else if (vol_reg != '0)
                        begin
                            vol_next = vol_reg - 4'd1;
                        end
                    end
                end
            end
            OP_TRIGGER:
            begin
                lfsr_next = LFSR_SEED;
                if (len_reg == '0)
                begin
                    len_next = LEN_FULL;
                end
                env_next = cfg.envelope_period;
                vol_next = cfg.start_volume;
                on_next  = 1'b1;
            end
            OP_LENGTH:
            begin
                len_next = LEN_FULL - {1'b0, length_value};
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    // result taken from the state after the event
    assign res.noise_bit  = lfsr_next[0];
    assign res.channel_on = on_next;
    assign res.level      = (on_next && !lfsr_next[0]) ? vol_next : '0;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            period_reg <= '0;
            lfsr_reg   <= '0;
            len_reg    <= '0;
            env_reg    <= '0;
            vol_reg    <= '0;
            on_reg     <= 1'b0;
        end
        else if (advance)
        begin
            step_reg   <= step_next;
            period_reg <= period_next;
            lfsr_reg   <= lfsr_next;
            len_reg    <= len_next;
            env_reg    <= env_next;
            vol_reg    <= vol_next;
            on_reg     <= on_next;
        end
    end

endmodule

/* rtl/core/noise_channel_lfsr_envelope_top.sv */
// noise_channel_lfsr_envelope_top: noise channel with input and result registers
// depends on nc_pkg, nc_if, nc_cfg and nc_eng
//
//   channel | role   | payload
//   --------+--------+--------------------------------------
//   evt     | sink   | operation, length_value
//   res     | source | level, channel_on, noise_bit
//   cfg     | sink   | index, data (always ready)
//
// an item waits in the input register and the state update is combinational, so its
// result moves on to the result register; one item per cycle while results are taken
// reset clears the channel state, config registers and both valid flags
// a stalled result holds the result register, and the input register keeps
// accepting until both stages are full
`timescale 1ns / 1ps

module noise_channel_lfsr_envelope_top (
    input  logic     clk,
    input  logic     rst_n,
    nc_evt_if.sink   evt,
    nc_res_if.source res,
    nc_cfg_if.sink   cfg
);
    import nc_pkg::*;

    logic                in_valid_reg;
    op_t                 in_op_reg;
    logic [LEN_IN_W-1:0] in_len_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;

    logic advance;
    logic evt_take;
    cfg_t cfg_val;
    res_t eng_res;

    // handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !in_valid_reg || advance;
    assign evt_take  = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    // configuration registers
    nc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    // channel state and update
    nc_eng u_eng (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .operation    (in_op_reg),
        .length_value (in_len_reg),
        .cfg          (cfg_val),
        .res          (eng_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            in_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            in_op_reg  <= op_t'(evt.operation);
            in_len_reg <= evt.length_value;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.level      = out_res_reg.level;
    assign res.channel_on = out_res_reg.channel_on;
    assign res.noise_bit  = out_res_reg.noise_bit;

endmodule

/* verif/tb_noise_channel_lfsr_envelope_top.sv */
// tb_noise_channel_lfsr_envelope_top: self-checking bench for the noise channel
// directed and random event streams with random gaps, checked by an in-bench predictor
// depends on nc_pkg, nc_if and noise_channel_lfsr_envelope_top
`timescale 1ns / 1ps

module tb_noise_channel_lfsr_envelope_top;
    import nc_pkg::*;

    // bench constants
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;
    localparam logic [14:0]          SEED_ALL_ONES  = 15'h7FFF;
    localparam logic [6:0]           FULL_LENGTH    = 7'd64;
    localparam logic [23:0]          HALF_STEP_BASE = 24'd8;
    localparam logic [3:0]           TOP_VOLUME     = 4'hF;
    localparam logic [2:0]           ENVELOPE_STEP  = 3'd7;
    localparam int unsigned          MAX_WAIT       = 14;
    localparam int unsigned          SETTLE_CYCLES  = 4;
    localparam int unsigned          QUIET_LIMIT    = 2000;
    localparam int unsigned          RANDOM_PHASES  = 12;
    localparam int unsigned          PHASE_ITEMS    = 145;

    logic clk = 1'b0;
    logic rst_n;

    nc_evt_if evt_ch ();
    nc_res_if res_ch ();
    nc_cfg_if cfg_ch ();

    noise_channel_lfsr_envelope_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // predicted channel state and register settings
    cfg_t        live_cfg;
    logic [2:0]  seq_step;
    logic [23:0] period_cnt;
    logic [14:0] lfsr;
    logic [6:0]  len_cnt;
    logic [2:0]  env_cnt;
    logic [3:0]  vol;
    logic        sounding;

    res_t        due_results[$];
    int unsigned err_count    = 0;
    int unsigned quiet_cycles = 0;
    bit          idle_on      = 1'b0;
    bit          stall_on     = 1'b0;

    // clock
    always #6 clk = ~clk;

    // apply one event to the predicted state and return the output it leads to
    function automatic res_t apply_event(op_t op, logic [5:0] len);
        res_t        out;
        logic        fb;
        logic [23:0] reload;
        case (op)
            OP_TIMER:
            begin
                if (period_cnt <= 24'd1)
                begin
                    if (live_cfg.divide_ratio != 3'd0)
                        reload = {21'd0, live_cfg.divide_ratio}
                                 << (int'(live_cfg.clock_shift) + 4);
                    else
                        reload = HALF_STEP_BASE << live_cfg.clock_shift;
                    period_cnt = reload;
                    fb   = lfsr[0] ^ lfsr[1];
                    lfsr = {fb, lfsr[14:1]};
                    if (live_cfg.narrow_mode)
                        lfsr[6] = fb;
                end
                else
                begin
                    period_cnt = period_cnt - 24'd1;
                end
            end
            OP_FRAME:
            begin
                seq_step = seq_step + 3'd1;
                // length clock on even steps
                if (!seq_step[0] && live_cfg.length_enable && len_cnt != 7'd0)
                begin
                    len_cnt = len_cnt - 7'd1;
                    if (len_cnt == 7'd0)
                        sounding = 1'b0;
                end
                // envelope clock on the last step
                if (seq_step == ENVELOPE_STEP && live_cfg.envelope_period != 3'd0)
                begin
                    env_cnt = env_cnt - 3'd1;
                    if (env_cnt == 3'd0)
                    begin
                        env_cnt = live_cfg.envelope_period;
                        if (live_cfg.envelope_increase)
                        begin
                            if (vol != TOP_VOLUME)
                                vol = vol + 4'd1;
                        end
                        else if (vol != 4'd0)
                        begin
                            vol = vol - 4'd1;
                        end
                    end
                end
            end
            OP_TRIGGER:
            begin
                lfsr = SEED_ALL_ONES;
                if (len_cnt == 7'd0)
                    len_cnt = FULL_LENGTH;
                env_cnt  = live_cfg.envelope_period;
                vol      = live_cfg.start_volume;
                sounding = 1'b1;
            end
            default:
            begin
                len_cnt = FULL_LENGTH - {1'b0, len};
            end
        endcase
        out.level      = (sounding && !lfsr[0]) ? vol : 4'd0;
        out.channel_on = sounding;
        out.noise_bit  = lfsr[0];
        return out;
    endfunction

    // send one event item after a random gap, predict its output on acceptance
    task automatic send_event(op_t op, logic [5:0] len);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid        <= 1'b1;
        evt_ch.operation    <= op;
        evt_ch.length_value <= len;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        due_results.push_back(apply_event(op, len));
    endtask

    // register write; valid stays high so writes can go back to back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_DIVIDE_RATIO:      live_cfg.divide_ratio      = data[2:0];
            REG_CLOCK_SHIFT:       live_cfg.clock_shift       = data[3:0];
            REG_NARROW_MODE:       live_cfg.narrow_mode       = data[0];
            REG_LENGTH_ENABLE:     live_cfg.length_enable     = data[0];
            REG_ENVELOPE_PERIOD:   live_cfg.envelope_period   = data[2:0];
            REG_ENVELOPE_INCREASE: live_cfg.envelope_increase = data[0];
            REG_START_VOLUME:      live_cfg.start_volume      = data[3:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_ch.valid <= 1'b0;
    endtask

    // stop sending and wait until every predicted output has come back
    task automatic drain_idle();
        evt_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // events straight out of reset, LFSR still all zeros
    task automatic test_reset_state();
        send_event(OP_TIMER, 6'($urandom_range(0, 63)));
        send_event(OP_FRAME, 6'($urandom_range(0, 63)));
        send_event(OP_LENGTH, 6'd0);
        send_event(OP_TRIGGER, 6'($urandom_range(0, 63)));
        send_event(OP_TIMER, 6'($urandom_range(0, 63)));
    endtask

    // shortest length runs out and stops the channel, then a retrigger reloads it
    task automatic test_length_expiry();
        drain_idle();
        write_reg(REG_LENGTH_ENABLE, 8'hFF);
        write_reg(REG_START_VOLUME, 8'hFF);
        write_reg(REG_ENVELOPE_PERIOD, 8'hF8);
        end_writes();
        send_event(OP_LENGTH, 6'd63);
        send_event(OP_TRIGGER, 6'd0);
        send_event(OP_FRAME, 6'd63);
        send_event(OP_FRAME, 6'd0);
        send_event(OP_TRIGGER, 6'd63);
    endtask

    // envelope saturates at full volume going up and at silence going down
    task automatic test_envelope_limits();
        drain_idle();
        write_reg(REG_ENVELOPE_PERIOD, 8'h01);
        write_reg(REG_ENVELOPE_INCREASE, 8'h01);
        write_reg(REG_UNUSED, 8'hA5);
        end_writes();
        send_event(OP_TRIGGER, 6'd0);
        repeat (4) send_event(OP_FRAME, 6'($urandom_range(0, 63)));
        drain_idle();
        write_reg(REG_ENVELOPE_INCREASE, 8'hFE);
        write_reg(REG_START_VOLUME, 8'hF0);
        end_writes();
        send_event(OP_TRIGGER, 6'd0);
        repeat (8) send_event(OP_FRAME, 6'($urandom_range(0, 63)));
    endtask

    // one setting of the registers followed by a random event stream
    task automatic test_random_phase(int unsigned phase_no, int unsigned count);
        logic [7:0]  shift_data;
        logic [5:0]  len;
        int unsigned pick;
        op_t         op;
        drain_idle();
        if (phase_no < 2)
        begin
            // extremes: every field at its top, then every field at zero
            for (int i = 0; i <= int'(REG_START_VOLUME); i++)
                write_reg(CFG_IDX_W'(i), (phase_no == 0) ? 8'hFF : 8'h00);
            idle_on  = 1'b0;
            stall_on = (phase_no == 1);
        end
        else
        begin
            // small shifts mostly, so the LFSR gets to step
            shift_data = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) != 0)
                shift_data[3:2] = 2'b00;
            write_reg(REG_DIVIDE_RATIO, 8'($urandom_range(0, 255)));
            write_reg(REG_CLOCK_SHIFT, shift_data);
            write_reg(REG_NARROW_MODE, 8'($urandom_range(0, 255)));
            write_reg(REG_LENGTH_ENABLE, 8'($urandom_range(0, 255)));
            write_reg(REG_ENVELOPE_PERIOD, 8'($urandom_range(0, 255)));
            write_reg(REG_ENVELOPE_INCREASE, 8'($urandom_range(0, 255)));
            write_reg(REG_START_VOLUME, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
        end
        end_writes();
        // start a note, then mostly ticks with the odd reload or retrigger
        send_event(OP_LENGTH, 6'($urandom_range(32, 63)));
        send_event(OP_TRIGGER, 6'($urandom_range(0, 63)));
        for (int unsigned n = 2; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                op = OP_TIMER;
            else if (pick < 82)
                op = OP_FRAME;
            else if (pick < 90)
                op = OP_TRIGGER;
            else
                op = OP_LENGTH;
            len = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(48, 63));
            send_event(op, len);
        end
    endtask

    // result receiver with random stalls
    initial
    begin : result_sink
        int unsigned stall;
        forever
        begin
            stall = stall_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(res_ch.valid && res_ch.ready))
                @(posedge clk);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (due_results.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: level=%0d on=%0d bit=%0d",
                             res_ch.level, res_ch.channel_on, res_ch.noise_bit);
            end
            else
            begin
                want = due_results.pop_front();
                if (res_ch.level !== want.level || res_ch.channel_on !== want.channel_on
                    || res_ch.noise_bit !== want.noise_bit)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("mismatch: expected level=%0d on=%0d bit=%0d",
                                 want.level, want.channel_on, want.noise_bit);
                        $display("          got level=%0d on=%0d bit=%0d",
                                 res_ch.level, res_ch.channel_on, res_ch.noise_bit);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n               <= 1'b0;
        evt_ch.valid        <= 1'b0;
        evt_ch.operation    <= OP_TIMER;
        evt_ch.length_value <= 6'd0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_DIVIDE_RATIO;
        cfg_ch.data         <= 8'd0;
        live_cfg   = '0;
        seq_step   = 3'd0;
        period_cnt = 24'd0;
        lfsr       = 15'd0;
        len_cnt    = 7'd0;
        env_cnt    = 3'd0;
        vol        = 4'd0;
        sounding   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_length_expiry();
        test_envelope_limits();
        for (int unsigned p = 0; p < RANDOM_PHASES; p++)
            test_random_phase(p, PHASE_ITEMS);
        drain_idle();

        if (err_count == 0 && due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
